@@ src/u8dec_pkg.sv @@
// Shared types and constants for the UTF-8 code point decoder.
// Used by u8dec_step, u8dec_obuf and utf8_codepoint_decoder_core; no dependencies.
package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned OutW   = CpW + CountW;

  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendOne   = 2'd1;
  localparam logic [1:0] PendTwo   = 2'd2;
  localparam logic [1:0] PendThree = 2'd3;

  localparam logic [CountW-1:0] Len0 = 3'd0;
  localparam logic [CountW-1:0] Len1 = 3'd1;
  localparam logic [CountW-1:0] Len2 = 3'd2;
  localparam logic [CountW-1:0] Len3 = 3'd3;
  localparam logic [CountW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [1:0]        bytes_pending;
    logic [CpW-1:0]    partial_value;
    logic [CountW-1:0] sequence_length;
  } seq_state_t;

  typedef struct packed {
    logic              valid;
    logic [CpW-1:0]    code_point;
    logic [CountW-1:0] byte_count;
  } cp_result_t;

endpackage

@@ src/u8dec_step.sv @@
// Combinational decode of one text byte against the open sequence state.
// Depends on u8dec_pkg for the state and result types.
module u8dec_step import u8dec_pkg::*; (
  input  logic [ByteW-1:0] text_byte,
  input  seq_state_t       state_cur,
  output seq_state_t       state_nxt,
  output cp_result_t       result
);

  logic [CpW-1:0] cont_bits;
  logic [CpW-1:0] merged;
  logic [1:0]     pend_dec;

  always_comb begin
    cont_bits = '0;
    unique case (state_cur.bytes_pending)
      PendThree: cont_bits = CpW'({text_byte[5:0], 12'd0});
      PendTwo:   cont_bits = CpW'({text_byte[5:0], 6'd0});
      default:   cont_bits = CpW'(text_byte[5:0]);
    endcase
    merged   = state_cur.partial_value | cont_bits;
    pend_dec = state_cur.bytes_pending - 2'd1;
  end

  always_comb begin
    state_nxt = '0;
    result    = '0;
    if (text_byte == '0) begin
      state_nxt = '0;
    end else if (state_cur.bytes_pending != PendNone &&
                 (text_byte & ContMask) == ContCode) begin
      if (pend_dec == PendNone) begin
        result.valid      = 1'b1;
        result.code_point = merged;
        result.byte_count = state_cur.sequence_length;
      end else begin
        state_nxt.bytes_pending   = pend_dec;
        state_nxt.partial_value   = merged;
        state_nxt.sequence_length = state_cur.sequence_length;
      end
    end else if (text_byte[7] == 1'b0) begin
      result.valid      = 1'b1;
      result.code_point = CpW'(text_byte);
      result.byte_count = Len1;
    end else if ((text_byte & Lead2Mask) == Lead2Code) begin
      state_nxt.bytes_pending   = PendOne;
      state_nxt.partial_value   = CpW'({text_byte[4:0], 6'd0});
      state_nxt.sequence_length = Len2;
    end else if ((text_byte & Lead3Mask) == Lead3Code) begin
      state_nxt.bytes_pending   = PendTwo;
      state_nxt.partial_value   = CpW'({text_byte[3:0], 12'd0});
      state_nxt.sequence_length = Len3;
    end else if ((text_byte & Lead4Mask) == Lead4Code) begin
      state_nxt.bytes_pending   = PendThree;
      state_nxt.partial_value   = CpW'({text_byte[2:0], 18'd0});
      state_nxt.sequence_length = Len4;
    end else begin
      state_nxt = '0;
    end
  end

endmodule

@@ src/u8dec_obuf.sv @@
// Two-entry output queue that holds decoded results until the sink takes them.
// Depends on u8dec_pkg for widths.
module u8dec_obuf import u8dec_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [OutW-1:0] push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [OutW-1:0] head_data
);

  logic [1:0]      count_r, count_nxt;
  logic [OutW-1:0] slot0_r, slot0_nxt;
  logic [OutW-1:0] slot1_r, slot1_nxt;
  logic            pop;

  assign out_valid = (count_r != 2'd0);
  assign head_data = slot0_r;
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    count_nxt = count_r;
    if (pop) begin
      if (count_r == 2'd2) begin
        slot0_nxt = slot1_r;
        if (push) begin
          slot1_nxt = push_data;
        end
      end else if (push) begin
        slot0_nxt = push_data;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
    end
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

@@ src/utf8_codepoint_decoder_core.sv @@
// Top level of the UTF-8 code point decoder: sequence state register, decode step
// and output queue. Depends on u8dec_pkg, u8dec_step and u8dec_obuf.
//
// The decoder takes one byte of UTF-8 text per cycle and emits a code point with
// its byte count when a sequence of one to four bytes completes; the result is
// pushed into the output queue as the byte that completes it is taken. The
// sequence state is updated by a single layer of decode logic per transaction.
// A two-entry output queue lets input continue while a result waits; input
// stalls only when both entries are held. A zero byte ends the string and
// drops any open sequence, stray continuation bytes and bytes 0xF8 to 0xFF are
// dropped, and an interrupted sequence is discarded with the interrupting byte
// decoded as a new lead. Overlong forms and surrogates are not checked.
module utf8_codepoint_decoder_core import u8dec_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] text_byte
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OutW-1:0] out_tdata   // [20:0] code_point, [23:21] byte_count
);

  seq_state_t state_r, state_nxt, step_state;
  cp_result_t step_result;
  logic       in_accept;
  logic       obuf_full;

  assign in_tready = !obuf_full;
  assign in_accept = in_tvalid && in_tready;

  u8dec_step u_step (
    .text_byte (in_tdata),
    .state_cur (state_r),
    .state_nxt (step_state),
    .result    (step_result)
  );

  always_comb begin
    state_nxt = state_r;
    if (in_accept) begin
      state_nxt = step_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  u8dec_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && step_result.valid),
    .push_data ({step_result.byte_count, step_result.code_point}),
    .full      (obuf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head_data (out_tdata)
  );

endmodule
